// File: sv/pvws_pkg.sv
// Shared types and constants for the particle Verlet wall step pipeline.
package pvws_pkg;

    localparam int DIM_W   = 15;
    localparam int MODE_W  = 2;
    localparam int TEMP_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLE_HALF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THERMO_EN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LEFT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_RIGHT  = 3'd6;

    // Central partition modes
    localparam logic [MODE_W-1:0] WALL_NONE     = 2'd0;
    localparam logic [MODE_W-1:0] WALL_HOLE     = 2'd1;
    localparam logic [MODE_W-1:0] WALL_BLOCK_LR = 2'd2;
    localparam logic [MODE_W-1:0] WALL_BLOCK_RL = 2'd3;

    localparam int THERMO_LEFT_BIT  = 0;
    localparam int THERMO_RIGHT_BIT = 1;

    // Thermostat arithmetic
    localparam int          Q_FRAC     = 16;            // T/ec and lambda fraction bits
    localparam int          LAM_RND    = 15;            // rounding bit / arg pre-shift
    localparam int          LAM_W      = 31;            // lambda significant bits
    localparam logic [63:0] Q_CAP      = 64'd1 << 46;
    localparam logic [63:0] ONE_Q16    = 64'd65536;
    localparam int          SQRT_STEPS = 32;

    localparam logic [DIM_W-1:0]  RST_HALF_WIDTH  = 15'd256;
    localparam logic [DIM_W-1:0]  RST_HALF_HEIGHT = 15'd128;
    localparam logic [DIM_W-1:0]  RST_HOLE_HALF   = 15'd16;
    localparam logic [TEMP_W-1:0] RST_TEMP        = 24'd256;

    typedef struct packed {
        logic [DIM_W-1:0]  half_width;
        logic [DIM_W-1:0]  half_height;
        logic [DIM_W-1:0]  hole_half;
        logic [MODE_W-1:0] wall_mode;
        logic [1:0]        thermo_en;
        logic [TEMP_W-1:0] temp_left;
        logic [TEMP_W-1:0] temp_right;
    } t_cfg;

endpackage

// File: sv/pvws_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module pvws_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 50,
    parameter int PAY_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_vld,
    output logic [NUM_W-1:0] o_quo,
    output logic [PAY_W-1:0] o_pay
);

    logic [NUM_W-1:0] r_vld;
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [PAY_W-1:0] r_pay [NUM_W];

    logic [DEN_W-1:0] a_rem [NUM_W];
    logic [DEN_W-1:0] a_den [NUM_W];
    logic [NUM_W-1:0] a_num [NUM_W];
    logic [NUM_W-1:0] a_quo [NUM_W];
    logic [PAY_W-1:0] a_pay [NUM_W];

    logic [DEN_W:0]   w_trial [NUM_W];
    logic [NUM_W-1:0] w_ge;
    logic [DEN_W-1:0] n_rem [NUM_W];
    logic [NUM_W-1:0] n_num [NUM_W];
    logic [NUM_W-1:0] n_quo [NUM_W];

    assign a_rem[0] = '0;
    assign a_den[0] = i_den;
    assign a_num[0] = i_num;
    assign a_quo[0] = '0;
    assign a_pay[0] = i_pay;

    for (genvar k = 1; k < NUM_W; k++) begin : g_src
        assign a_rem[k] = r_rem[k-1];
        assign a_den[k] = r_den[k-1];
        assign a_num[k] = r_num[k-1];
        assign a_quo[k] = r_quo[k-1];
        assign a_pay[k] = r_pay[k-1];
    end

    always_comb begin
        for (int k = 0; k < NUM_W; k++) begin
            w_trial[k] = {a_rem[k], a_num[k][NUM_W-1]};
            w_ge[k]    = (w_trial[k] >= {1'b0, a_den[k]});
            n_rem[k]   = w_ge[k] ? DEN_W'(w_trial[k] - {1'b0, a_den[k]}) : DEN_W'(w_trial[k]);
            n_num[k]   = a_num[k] << 1;
            n_quo[k]   = {a_quo[k][NUM_W-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NUM_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= a_den[k];
                r_num[k] <= n_num[k];
                r_quo[k] <= n_quo[k];
                r_pay[k] <= a_pay[k];
            end
        end
    end

    assign o_vld = r_vld[NUM_W-1];
    assign o_quo = r_quo[NUM_W-1];
    assign o_pay = r_pay[NUM_W-1];

endmodule

// File: sv/pvws_sqrt.sv
// Pipelined 64-bit integer square root, one result bit per stage, with side payload.
module pvws_sqrt #(
    parameter int PAY_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [63:0]      i_arg,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_vld,
    output logic [31:0]      o_root,
    output logic [PAY_W-1:0] o_pay
);

    localparam int N = pvws_pkg::SQRT_STEPS;

    logic [N-1:0]     r_vld;
    logic [63:0]      r_rad [N];
    logic [63:0]      r_res [N];
    logic [PAY_W-1:0] r_pay [N];

    logic [63:0]      a_rad [N];
    logic [63:0]      a_res [N];
    logic [PAY_W-1:0] a_pay [N];

    logic [63:0] w_bit  [N];
    logic [63:0] w_sum  [N];
    logic [63:0] n_rad  [N];
    logic [63:0] n_res  [N];

    assign a_rad[0] = i_arg;
    assign a_res[0] = '0;
    assign a_pay[0] = i_pay;

    for (genvar k = 1; k < N; k++) begin : g_src
        assign a_rad[k] = r_rad[k-1];
        assign a_res[k] = r_res[k-1];
        assign a_pay[k] = r_pay[k-1];
    end

    always_comb begin
        for (int k = 0; k < N; k++) begin
            w_bit[k] = 64'd1 << (62 - 2 * k);
            w_sum[k] = a_res[k] + w_bit[k];
            if (a_rad[k] >= w_sum[k]) begin
                n_rad[k] = a_rad[k] - w_sum[k];
                n_res[k] = (a_res[k] >> 1) + w_bit[k];
            end else begin
                n_rad[k] = a_rad[k];
                n_res[k] = a_res[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rad[k] <= n_rad[k];
                r_res[k] <= n_res[k];
                r_pay[k] <= a_pay[k];
            end
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_root = r_res[N-1][31:0];
    assign o_pay  = r_pay[N-1];

endmodule

// File: sv/pvws_xwall.sv
// One side wall (left or right): reflection plus optional thermostat velocity rescale.
module pvws_xwall #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8,
    parameter bit SIDE_RIGHT = 1'b1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  pvws_pkg::t_cfg          i_cfg,
    input  logic                    i_vld,
    input  logic [6*COORD_BITS-1:0] i_pos,
    input  logic                    i_flag,
    output logic                    o_vld,
    output logic [6*COORD_BITS-1:0] o_pos,
    output logic                    o_flag
);

    localparam int C     = COORD_BITS;
    localparam int PW6   = 6 * C;
    localparam int KW    = ((C > pvws_pkg::DIM_W + FRAC_BITS) ? C
                           : pvws_pkg::DIM_W + FRAC_BITS) + 3;
    localparam int SQW   = 2 * C + 2;
    localparam int EC_W  = (SQW > 64) ? 64 : SQW;
    localparam int NUM_W = pvws_pkg::TEMP_W + FRAC_BITS + pvws_pkg::Q_FRAC;
    localparam int PAY_W = PW6 + 3;
    localparam int PRW   = C + 1 + pvws_pkg::LAM_W;

    // position slots: 0 px, 1 py, 2 cx, 3 cy, 4 nx, 5 ny
    function automatic logic signed [C-1:0] mirror(input logic signed [C-1:0] v,
                                                   input logic signed [KW-1:0] k);
        return C'(k - KW'(v));
    endfunction

    // ---- stage a: wall test and reflection
    logic signed [C-1:0]  w_px, w_cx, w_nx;
    logic signed [KW-1:0] w_wk, w_kk;
    logic                 w_hit, w_th;
    logic [PW6-1:0]       n_a_pos;

    logic           r_a_vld, r_a_flag, r_a_th;
    logic [PW6-1:0] r_a_pos;

    assign w_px = i_pos[0*C +: C];
    assign w_cx = i_pos[2*C +: C];
    assign w_nx = i_pos[4*C +: C];
    assign w_wk = signed'(KW'({i_cfg.half_width, {FRAC_BITS{1'b0}}}));
    assign w_kk = SIDE_RIGHT ? (w_wk <<< 1) : -(w_wk <<< 1);
    assign w_hit = SIDE_RIGHT ? (KW'(w_nx) > w_wk) : (KW'(w_nx) < -w_wk);
    assign w_th  = w_hit && (SIDE_RIGHT ? i_cfg.thermo_en[pvws_pkg::THERMO_RIGHT_BIT]
                                        : i_cfg.thermo_en[pvws_pkg::THERMO_LEFT_BIT]);

    always_comb begin
        n_a_pos = i_pos;
        if (w_hit) begin
            n_a_pos[0*C +: C] = mirror(w_px, w_kk);
            n_a_pos[2*C +: C] = mirror(w_cx, w_kk);
            n_a_pos[4*C +: C] = mirror(w_nx, w_kk);
        end
    end

    // ---- stage b: velocity squares
    logic signed [C:0] w_vx, w_vy;
    logic [C:0]        w_ux, w_uy;

    logic           r_b_vld, r_b_flag, r_b_th;
    logic [PW6-1:0] r_b_pos;
    logic [SQW-1:0] r_b_sqx, r_b_sqy;

    assign w_vx = (C+1)'(signed'(r_a_pos[4*C +: C])) - (C+1)'(signed'(r_a_pos[2*C +: C]));
    assign w_vy = (C+1)'(signed'(r_a_pos[5*C +: C])) - (C+1)'(signed'(r_a_pos[3*C +: C]));
    assign w_ux = w_vx[C] ? (C+1)'(-w_vx) : (C+1)'(w_vx);
    assign w_uy = w_vy[C] ? (C+1)'(-w_vy) : (C+1)'(w_vy);

    // ---- stage c: kinetic energy, saturated to 64 bits
    logic [SQW-1:0]  w_sum;
    logic [EC_W-1:0] w_ec;

    logic            r_c_vld, r_c_flag, r_c_th, r_c_ecz;
    logic [PW6-1:0]  r_c_pos;
    logic [EC_W-1:0] r_c_ec;

    assign w_sum = r_b_sqx + r_b_sqy;

    if (SQW > 64) begin : g_ec_sat
        assign w_ec = (|w_sum[SQW-1:64]) ? '1 : w_sum[63:0];
    end else begin : g_ec_full
        assign w_ec = w_sum;
    end

    // ---- divider: q = (T << (F+16)) / ec
    logic [NUM_W-1:0] w_num;
    logic             w_d_vld;
    logic [NUM_W-1:0] w_quo;
    logic [PAY_W-1:0] w_d_pay;

    assign w_num = {SIDE_RIGHT ? i_cfg.temp_right : i_cfg.temp_left,
                    {(FRAC_BITS + pvws_pkg::Q_FRAC){1'b0}}};

    pvws_div #(
        .NUM_W (NUM_W),
        .DEN_W (EC_W),
        .PAY_W (PAY_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r_c_vld),
        .i_num   (w_num),
        .i_den   (r_c_ec),
        .i_pay   ({r_c_ecz, r_c_th, r_c_flag, r_c_pos}),
        .o_vld   (w_d_vld),
        .o_quo   (w_quo),
        .o_pay   (w_d_pay)
    );

    // ---- cap q and form sqrt argument (1 + q) << 15
    logic [63:0] w_q64, w_qcap;

    logic             r_q_vld;
    logic [63:0]      r_q_arg;
    logic [PAY_W-1:0] r_q_pay;

    assign w_q64  = 64'(w_quo);
    assign w_qcap = (w_q64 > pvws_pkg::Q_CAP) ? pvws_pkg::Q_CAP : w_q64;

    logic             w_r_vld;
    logic [31:0]      w_root;
    logic [PAY_W-1:0] w_r_pay;

    pvws_sqrt #(
        .PAY_W (PAY_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r_q_vld),
        .i_arg   (r_q_arg),
        .i_pay   (r_q_pay),
        .o_vld   (w_r_vld),
        .o_root  (w_root),
        .o_pay   (w_r_pay)
    );

    // ---- stage s1: velocity magnitude and sign again
    logic [PW6-1:0]    w_rpos;
    logic signed [C:0] w_svx, w_svy;

    logic                       r_s1_vld, r_s1_flag, r_s1_sc, r_s1_sx, r_s1_sy;
    logic [PW6-1:0]             r_s1_pos;
    logic [C:0]                 r_s1_ux, r_s1_uy;
    logic [pvws_pkg::LAM_W-1:0] r_s1_lam;

    assign w_rpos = w_r_pay[PW6-1:0];
    assign w_svx  = (C+1)'(signed'(w_rpos[4*C +: C])) - (C+1)'(signed'(w_rpos[2*C +: C]));
    assign w_svy  = (C+1)'(signed'(w_rpos[5*C +: C])) - (C+1)'(signed'(w_rpos[3*C +: C]));

    // ---- stage s2: scale by lambda, saturate, round
    logic [PRW-1:0] w_prx, w_pry;
    logic [63:0]    w_mx, w_my;

    logic           r_s2_vld, r_s2_flag, r_s2_sc, r_s2_sx, r_s2_sy;
    logic [PW6-1:0] r_s2_pos;
    logic [C-1:0]   r_s2_mx, r_s2_my;

    assign w_prx = PRW'(r_s1_ux) * PRW'(r_s1_lam);
    assign w_pry = PRW'(r_s1_uy) * PRW'(r_s1_lam);

    if (PRW > 64) begin : g_pr_sat
        assign w_mx = (|w_prx[PRW-1:64]) ? '1 : w_prx[63:0];
        assign w_my = (|w_pry[PRW-1:64]) ? '1 : w_pry[63:0];
    end else begin : g_pr_full
        assign w_mx = 64'(w_prx);
        assign w_my = 64'(w_pry);
    end

    // ---- stage s3: rebuild prev and next around cur
    logic [C-1:0]   w_vxs, w_vys;
    logic [PW6-1:0] n_o_pos;

    logic           r_o_vld, r_o_flag;
    logic [PW6-1:0] r_o_pos;

    assign w_vxs = r_s2_sx ? -r_s2_mx : r_s2_mx;
    assign w_vys = r_s2_sy ? -r_s2_my : r_s2_my;

    always_comb begin
        n_o_pos = r_s2_pos;
        if (r_s2_sc) begin
            n_o_pos[4*C +: C] = r_s2_pos[2*C +: C] + w_vxs;
            n_o_pos[5*C +: C] = r_s2_pos[3*C +: C] + w_vys;
            n_o_pos[0*C +: C] = r_s2_pos[2*C +: C] - w_vxs;
            n_o_pos[1*C +: C] = r_s2_pos[3*C +: C] - w_vys;
        end
    end

    // ---- valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_c_vld  <= 1'b0;
            r_q_vld  <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (i_en) begin
            r_a_vld  <= i_vld;
            r_b_vld  <= r_a_vld;
            r_c_vld  <= r_b_vld;
            r_q_vld  <= w_d_vld;
            r_s1_vld <= w_r_vld;
            r_s2_vld <= r_s1_vld;
            r_o_vld  <= r_s2_vld;
        end
    end

    // ---- payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_pos  <= n_a_pos;
            r_a_flag <= i_flag;
            r_a_th   <= w_th;

            r_b_pos  <= r_a_pos;
            r_b_flag <= r_a_flag;
            r_b_th   <= r_a_th;
            r_b_sqx  <= SQW'(w_ux) * SQW'(w_ux);
            r_b_sqy  <= SQW'(w_uy) * SQW'(w_uy);

            r_c_pos  <= r_b_pos;
            r_c_flag <= r_b_flag;
            r_c_th   <= r_b_th;
            r_c_ec   <= w_ec;
            r_c_ecz  <= (w_sum == '0);

            r_q_arg  <= (w_qcap + pvws_pkg::ONE_Q16) << pvws_pkg::LAM_RND;
            r_q_pay  <= w_d_pay;

            r_s1_pos  <= w_rpos;
            r_s1_flag <= w_r_pay[PW6];
            r_s1_sc   <= w_r_pay[PW6+1] && !w_r_pay[PW6+2];
            r_s1_sx   <= w_svx[C];
            r_s1_sy   <= w_svy[C];
            r_s1_ux   <= w_svx[C] ? (C+1)'(-w_svx) : (C+1)'(w_svx);
            r_s1_uy   <= w_svy[C] ? (C+1)'(-w_svy) : (C+1)'(w_svy);
            r_s1_lam  <= w_root[pvws_pkg::LAM_W-1:0];

            r_s2_pos  <= r_s1_pos;
            r_s2_flag <= r_s1_flag;
            r_s2_sc   <= r_s1_sc;
            r_s2_sx   <= r_s1_sx;
            r_s2_sy   <= r_s1_sy;
            r_s2_mx   <= C'(w_mx >> pvws_pkg::Q_FRAC) + C'(w_mx[pvws_pkg::LAM_RND]);
            r_s2_my   <= C'(w_my >> pvws_pkg::Q_FRAC) + C'(w_my[pvws_pkg::LAM_RND]);

            r_o_pos   <= n_o_pos;
            r_o_flag  <= r_s2_flag;
        end
    end

    assign o_vld  = r_o_vld;
    assign o_pos  = r_o_pos;
    assign o_flag = r_o_flag;

endmodule

// File: sv/particle_verlet_wall_step.sv
// Top level of the particle Verlet wall step pipeline.
//
// One particle per beat: the block forms next = 2*cur - prev, reflects at the
// top and bottom walls, then at the right and the left wall (each with an
// optional thermostat that rescales the velocity by sqrt((1+T/ec)/2)), and
// last applies the central partition and updates the side flag. It accepts a
// beat every cycle while the output is not stalled. The pipeline depth is set
// by the two wall units, each holding a bit-per-stage divider for T/ec and a
// 32-stage square root. The whole pipeline advances together: it moves
// whenever the output register is empty or being taken, so o_s_tready follows
// i_m_tready and the output valid. The user must write configuration only
// while the pipeline is empty; the block itself does not enforce it.
module particle_verlet_wall_step #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [pvws_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pvws_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // input beat
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // prev_x, prev_y, cur_x, cur_y (lowest first), zero filled
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]   i_s_tdata,
    // on_right
    input  logic [0:0]                          i_s_tuser,
    // result beat
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // out_prev_x, out_prev_y, out_cur_x, out_cur_y, next_x, next_y (lowest first)
    output logic [((6*COORD_BITS+7)/8)*8-1:0]   o_m_tdata,
    // out_on_right
    output logic [0:0]                          o_m_tuser
);

    localparam int C     = COORD_BITS;
    localparam int PW6   = 6 * C;
    localparam int OTD_W = ((6*C+7)/8)*8;
    localparam int KW    = ((C > pvws_pkg::DIM_W + FRAC_BITS) ? C
                           : pvws_pkg::DIM_W + FRAC_BITS) + 3;

    function automatic logic signed [C-1:0] mirror(input logic signed [C-1:0] v,
                                                   input logic signed [KW-1:0] k);
        return C'(k - KW'(v));
    endfunction

    pvws_pkg::t_cfg r_cfg;
    logic           w_en;

    // Pipeline advances when the output slot is free or drained this cycle
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // ---- configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_width  <= pvws_pkg::RST_HALF_WIDTH;
            r_cfg.half_height <= pvws_pkg::RST_HALF_HEIGHT;
            r_cfg.hole_half   <= pvws_pkg::RST_HOLE_HALF;
            r_cfg.wall_mode   <= pvws_pkg::WALL_NONE;
            r_cfg.thermo_en   <= '0;
            r_cfg.temp_left   <= pvws_pkg::RST_TEMP;
            r_cfg.temp_right  <= pvws_pkg::RST_TEMP;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                pvws_pkg::CFG_HALF_WIDTH:  r_cfg.half_width  <= i_cfg_wdata[pvws_pkg::DIM_W-1:0];
                pvws_pkg::CFG_HALF_HEIGHT: r_cfg.half_height <= i_cfg_wdata[pvws_pkg::DIM_W-1:0];
                pvws_pkg::CFG_HOLE_HALF:   r_cfg.hole_half   <= i_cfg_wdata[pvws_pkg::DIM_W-1:0];
                pvws_pkg::CFG_WALL_MODE:   r_cfg.wall_mode   <= i_cfg_wdata[pvws_pkg::MODE_W-1:0];
                pvws_pkg::CFG_THERMO_EN:   r_cfg.thermo_en   <= i_cfg_wdata[1:0];
                pvws_pkg::CFG_TEMP_LEFT:   r_cfg.temp_left   <= i_cfg_wdata;
                pvws_pkg::CFG_TEMP_RIGHT:  r_cfg.temp_right  <= i_cfg_wdata;
                default: ;  // index beyond the register list: ignored
            endcase
        end
    end

    // ---- stage 1: Verlet inertia step, wrapped to C bits
    logic signed [C-1:0] w_px, w_py, w_cx, w_cy;
    logic                r1_vld, r1_flag;
    logic [PW6-1:0]      r1_pos;

    assign w_px = i_s_tdata[0*C +: C];
    assign w_py = i_s_tdata[1*C +: C];
    assign w_cx = i_s_tdata[2*C +: C];
    assign w_cy = i_s_tdata[3*C +: C];

    // ---- stages 2 and 3: top wall, then bottom wall
    logic signed [KW-1:0] w_hk;
    logic signed [C-1:0]  w2_ny, w3_ny;
    logic [PW6-1:0]       n2_pos, n3_pos;
    logic                 r2_vld, r2_flag, r3_vld, r3_flag;
    logic [PW6-1:0]       r2_pos, r3_pos;

    assign w_hk  = signed'(KW'({r_cfg.half_height, {FRAC_BITS{1'b0}}}));
    assign w2_ny = r1_pos[5*C +: C];
    assign w3_ny = r2_pos[5*C +: C];

    always_comb begin
        n2_pos = r1_pos;
        if (KW'(w2_ny) > w_hk) begin
            n2_pos[1*C +: C] = mirror(r1_pos[1*C +: C], w_hk <<< 1);
            n2_pos[3*C +: C] = mirror(r1_pos[3*C +: C], w_hk <<< 1);
            n2_pos[5*C +: C] = mirror(w2_ny, w_hk <<< 1);
        end
        n3_pos = r2_pos;
        if (KW'(w3_ny) < -w_hk) begin
            n3_pos[1*C +: C] = mirror(r2_pos[1*C +: C], -(w_hk <<< 1));
            n3_pos[3*C +: C] = mirror(r2_pos[3*C +: C], -(w_hk <<< 1));
            n3_pos[5*C +: C] = mirror(w3_ny, -(w_hk <<< 1));
        end
    end

    // ---- side walls: right first, then left
    logic           wr_vld, wr_flag, wl_vld, wl_flag;
    logic [PW6-1:0] wr_pos, wl_pos;

    pvws_xwall #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .SIDE_RIGHT (1'b1)
    ) u_wall_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_vld   (r3_vld),
        .i_pos   (r3_pos),
        .i_flag  (r3_flag),
        .o_vld   (wr_vld),
        .o_pos   (wr_pos),
        .o_flag  (wr_flag)
    );

    pvws_xwall #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .SIDE_RIGHT (1'b0)
    ) u_wall_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_vld   (wr_vld),
        .i_pos   (wr_pos),
        .i_flag  (wr_flag),
        .o_vld   (wl_vld),
        .o_pos   (wl_pos),
        .o_flag  (wl_flag)
    );

    // ---- final stage: central partition and side flag, into output register
    logic signed [KW-1:0] w_hole, w_ny_k;
    logic signed [C-1:0]  w_nx;
    logic                 w_solid;
    logic [PW6-1:0]       n_o_pos;
    logic                 n_o_flag;
    logic                 r_o_vld, r_o_flag;
    logic [PW6-1:0]       r_o_pos;

    assign w_hole  = signed'(KW'({r_cfg.hole_half, {FRAC_BITS{1'b0}}}));
    assign w_ny_k  = KW'(signed'(wl_pos[5*C +: C]));
    assign w_solid = (w_ny_k >= w_hole) || (w_ny_k <= -w_hole);

    always_comb begin
        n_o_pos  = wl_pos;
        n_o_flag = wl_flag;
        w_nx     = wl_pos[4*C +: C];
        if (r_cfg.wall_mode == pvws_pkg::WALL_NONE) begin
            if (w_nx > 0) n_o_flag = 1'b1;
            if (w_nx < 0) n_o_flag = 1'b0;
        end else begin
            // crossing left to right
            if (w_nx > 0 && !n_o_flag) begin
                if (w_solid || r_cfg.wall_mode == pvws_pkg::WALL_BLOCK_LR) begin
                    n_o_pos[0*C +: C] = -wl_pos[0*C +: C];
                    n_o_pos[2*C +: C] = -wl_pos[2*C +: C];
                    n_o_pos[4*C +: C] = -wl_pos[4*C +: C];
                    w_nx = -wl_pos[4*C +: C];
                end else begin
                    n_o_flag = 1'b1;
                end
            end
            // crossing right to left
            if (w_nx < 0 && n_o_flag) begin
                if (w_solid || r_cfg.wall_mode == pvws_pkg::WALL_BLOCK_RL) begin
                    n_o_pos[0*C +: C] = -wl_pos[0*C +: C];
                    n_o_pos[2*C +: C] = -wl_pos[2*C +: C];
                    n_o_pos[4*C +: C] = -wl_pos[4*C +: C];
                end else begin
                    n_o_flag = 1'b0;
                end
            end
        end
    end

    // ---- valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld  <= i_s_tvalid;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r_o_vld <= wl_vld;
        end
    end

    // ---- payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_pos   <= {(w_cy <<< 1) - w_py, (w_cx <<< 1) - w_px, w_cy, w_cx, w_py, w_px};
            r1_flag  <= i_s_tuser[0];
            r2_pos   <= n2_pos;
            r2_flag  <= r1_flag;
            r3_pos   <= n3_pos;
            r3_flag  <= r2_flag;
            r_o_pos  <= n_o_pos;
            r_o_flag <= n_o_flag;
        end
    end

    assign o_m_tvalid   = r_o_vld;
    assign o_m_tdata    = OTD_W'(r_o_pos);
    assign o_m_tuser[0] = r_o_flag;

endmodule

// File: sv/pvws_checker.sv
// Port-level checker for the particle Verlet wall step, bound to the top level.
module pvws_checker #(
    parameter int COORD_BITS = 24
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [((6*COORD_BITS+7)/8)*8-1:0] o_m_tdata,
    input logic [0:0]                        o_m_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a held result freezes the whole pipeline
    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while result stalled");

    // empty output slot always lets beats in
    a_free_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // input is never stalled while the sink is ready: ready tracks the sink
    a_ready_sink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_m_tready |-> o_s_tready)
        else $error("input stalled while sink ready");

endmodule

bind particle_verlet_wall_step pvws_checker #(.COORD_BITS(COORD_BITS)) u_pvws_checker (.*);

// File: bench/testbench.sv
// Self-checking bench for the particle Verlet wall step block.
`timescale 1ns / 100ps

// Expected-result store: predicts one result per accepted particle and
// compares results in order.
class wall_step_scoreboard;
    localparam int CB = 24;
    localparam int FB = 8;

    typedef struct {
        logic [CB-1:0] px, py, cx, cy, nx, ny;
        logic          right;
    } t_particle;

    t_particle pending_q[$];
    int        mismatches;

    // shadow copy of the configuration registers
    logic [14:0] half_width, half_height, hole_half;
    logic [1:0]  wall_mode, thermo_en;
    logic [23:0] temp_left, temp_right;

    function new();
        mismatches  = 0;
        half_width  = 15'd256;
        half_height = 15'd128;
        hole_half   = 15'd16;
        wall_mode   = pvws_pkg::WALL_NONE;
        thermo_en   = 2'd0;
        temp_left   = 24'd256;
        temp_right  = 24'd256;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
        case (idx)
            pvws_pkg::CFG_HALF_WIDTH:  half_width  = val[14:0];
            pvws_pkg::CFG_HALF_HEIGHT: half_height = val[14:0];
            pvws_pkg::CFG_HOLE_HALF:   hole_half   = val[14:0];
            pvws_pkg::CFG_WALL_MODE:   wall_mode   = val[1:0];
            pvws_pkg::CFG_THERMO_EN:   thermo_en   = val[1:0];
            pvws_pkg::CFG_TEMP_LEFT:   temp_left   = val;
            pvws_pkg::CFG_TEMP_RIGHT:  temp_right  = val;
            default: ;
        endcase
    endfunction

    // wrap to coordinate width, back to signed 64
    function longint wrap(longint v);
        logic [CB-1:0] t;
        t = v[CB-1:0];
        return longint'(signed'(t));
    endfunction

    function longint unsigned sat_mul(longint unsigned a, longint unsigned b);
        if (a != 0 && b > 64'hFFFF_FFFF_FFFF_FFFF / a) return 64'hFFFF_FFFF_FFFF_FFFF;
        return a * b;
    endfunction

    function longint unsigned mag(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function longint rescale(longint v, longint unsigned lam);
        longint unsigned m;
        m = sat_mul(mag(v), lam);
        m = (m >> 16) + ((m >> 15) & 1);
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    // full prediction of one particle; positions held as signed 64
    function t_particle advance(t_particle din);
        longint px, py, cx, cy, nx, ny, wv, hv, hl, k, vx, vy, sx, sy;
        longint unsigned ax, ay, ec, q, lam, tmp;
        logic right, solid, hot;
        t_particle r;
        px = longint'(signed'(din.px));
        py = longint'(signed'(din.py));
        cx = longint'(signed'(din.cx));
        cy = longint'(signed'(din.cy));
        right = din.right;
        wv = longint'(half_width) << FB;
        hv = longint'(half_height) << FB;
        hl = longint'(hole_half) << FB;
        nx = wrap(2 * cx - px);
        ny = wrap(2 * cy - py);
        if (ny > hv) begin
            py = wrap(2*hv - py); cy = wrap(2*hv - cy); ny = wrap(2*hv - ny);
        end
        if (ny < -hv) begin
            py = wrap(-2*hv - py); cy = wrap(-2*hv - cy); ny = wrap(-2*hv - ny);
        end
        // right wall then left wall; thermal walls rescale after the mirror
        for (int side = 1; side >= 0; side--) begin
            if (side == 1 ? nx > wv : nx < -wv) begin
                k = side == 1 ? 2*wv : -2*wv;
                px = wrap(k - px); cx = wrap(k - cx); nx = wrap(k - nx);
                hot = thermo_en[side == 1 ? pvws_pkg::THERMO_RIGHT_BIT
                                          : pvws_pkg::THERMO_LEFT_BIT];
                if (hot) begin
                    vx = nx - cx;
                    vy = ny - cy;
                    ax = sat_mul(mag(vx), mag(vx));
                    ay = sat_mul(mag(vy), mag(vy));
                    ec = (ax > 64'hFFFF_FFFF_FFFF_FFFF - ay) ? 64'hFFFF_FFFF_FFFF_FFFF : ax + ay;
                    if (ec != 0) begin
                        tmp = 64'(side == 1 ? temp_right : temp_left);
                        q = (tmp << (FB + 16)) / ec;
                        if (q > (64'd1 << 46)) q = 64'd1 << 46;
                        lam = int_sqrt((64'd65536 + q) << 15);
                        sx = rescale(vx, lam);
                        sy = rescale(vy, lam);
                        nx = wrap(cx + sx); ny = wrap(cy + sy);
                        px = wrap(cx - sx); py = wrap(cy - sy);
                    end
                end
            end
        end
        if (wall_mode == pvws_pkg::WALL_NONE) begin
            if (nx > 0) right = 1;
            else if (nx < 0) right = 0;
        end else begin
            solid = (ny >= hl) || (ny <= -hl);
            if (nx > 0 && !right) begin
                if (solid || wall_mode == pvws_pkg::WALL_BLOCK_LR) begin
                    px = wrap(-px); cx = wrap(-cx); nx = wrap(-nx);
                end else right = 1;
            end
            if (nx < 0 && right) begin
                if (solid || wall_mode == pvws_pkg::WALL_BLOCK_RL) begin
                    px = wrap(-px); cx = wrap(-cx); nx = wrap(-nx);
                end else right = 0;
            end
        end
        r.px = px[CB-1:0]; r.py = py[CB-1:0];
        r.cx = cx[CB-1:0]; r.cy = cy[CB-1:0];
        r.nx = nx[CB-1:0]; r.ny = ny[CB-1:0];
        r.right = right;
        return r;
    endfunction

    function void note_input(logic [95:0] data, logic on_right);
        t_particle p;
        p.px = data[23:0]; p.py = data[47:24];
        p.cx = data[71:48]; p.cy = data[95:72];
        p.right = on_right;
        pending_q.push_back(advance(p));
    endfunction

    function void check_result(logic [143:0] data, logic on_right);
        t_particle e;
        logic [144:0] want, got;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", data);
            return;
        end
        e = pending_q.pop_front();
        want = {e.right, e.ny, e.nx, e.cy, e.cx, e.py, e.px};
        got  = {on_right, data};
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: flag/ny/nx/cy/cx/py/px exp %h got %h", want, got);
        end
    endfunction
endclass

module testbench;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    logic [2:0]   i_cfg_index;
    logic [23:0]  i_cfg_wdata;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [95:0]  i_s_tdata;      // prev_x, prev_y, cur_x, cur_y
    logic [0:0]   i_s_tuser;      // on_right
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [143:0] o_m_tdata;      // out_prev_x, out_prev_y, out_cur_x, out_cur_y, next_x, next_y
    logic [0:0]   o_m_tuser;      // out_on_right

    wall_step_scoreboard motion_board;
    bit sink_busy;

    particle_verlet_wall_step dut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop, well past the slowest legal run
    initial begin
        #40ms;
        $display("** particle_verlet_wall_step: FAILED **");
        $finish;
    end

    // short gaps mostly, an occasional long one, and stretches with none
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random stall stretches on tready, compare at the rising edge
    initial begin
        i_m_tready = 0;
        sink_busy = 1;
        wait (i_rst_n);
        while (sink_busy) begin
            @(negedge i_clk);
            i_m_tready = 1;
            if ($urandom_range(0, 3) == 0) begin
                i_m_tready = 0;
                repeat (gap_len()) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            motion_board.check_result(o_m_tdata, o_m_tuser[0]);
    end

    task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_wr_en = 1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        motion_board.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_wr_en = 0;
    endtask

    // one beat; waits for the handshake at a rising edge
    task automatic send_particle(logic [23:0] px, py, cx, cy, logic side);
        int g;
        g = gap_len();
        repeat (g) @(negedge i_clk);
        i_s_tvalid = 1;
        i_s_tdata = {cy, cx, py, px};
        i_s_tuser = side;
        do @(posedge i_clk); while (!o_s_tready);
        motion_board.note_input(i_s_tdata, i_s_tuser[0]);
        @(negedge i_clk);
        i_s_tvalid = 0;
    endtask

    // drain: wait for all expectations, then the pipeline depth
    task automatic drain();
        while (motion_board.pending_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    // random particle near the walls of the current box, sometimes anywhere
    task automatic random_particle();
        logic [23:0] px, py, cx, cy;
        int wv, hv, vx, vy, span;
        wv = int'(motion_board.half_width) << 8;
        hv = int'(motion_board.half_height) << 8;
        if ($urandom_range(0, 9) == 0) begin
            px = 24'($urandom); py = 24'($urandom);
            cx = 24'($urandom); cy = 24'($urandom);
        end else begin
            span = $urandom_range(0, 3) == 0 ? 4096 : 600;
            vx = $urandom_range(0, 2*span) - span;
            vy = $urandom_range(0, 2*span) - span;
            case ($urandom_range(0, 3))
                0: cx = 24'(wv - $urandom_range(0, 700));
                1: cx = 24'(-wv + $urandom_range(0, 700));
                2: cx = 24'($urandom_range(0, 1400) - 700);
                default: cx = 24'($urandom_range(0, 2*wv) - wv);
            endcase
            cy = ($urandom_range(0, 2) == 0) ? 24'(hv - $urandom_range(0, 700))
                                             : 24'($urandom_range(0, 2*hv) - hv);
            if ($urandom_range(0, 1)) cy = -cy;
            px = cx - 24'(vx);
            py = cy - 24'(vy);
        end
        send_particle(px, py, cx, cy, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        logic [23:0] ext[4];
        motion_board = new();
        i_rst_n = 0;
        i_cfg_wr_en = 0;
        i_cfg_index = pvws_pkg::CFG_HALF_WIDTH;
        i_cfg_wdata = 0;
        i_s_tvalid = 0;
        i_s_tdata = 0;
        i_s_tuser = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: reset settings, extremes, walls, zero motion
        ext = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF};
        foreach (ext[i]) send_particle(ext[i], ext[(i+1)%4], ext[(i+2)%4], ext[(i+3)%4], i[0]);
        send_particle(24'd0, 24'd0, 24'd0, 24'd0, 1);                  // at rest, on zero
        send_particle(24'd65000, 24'd0, 24'd65500, 24'd0, 0);          // right wall
        send_particle(-24'sd65000, 24'd0, -24'sd65500, 24'd0, 1);      // left wall
        send_particle(24'd0, 24'd32000, 24'd0, 24'd32700, 0);          // top wall
        send_particle(24'd0, -24'sd32000, 24'd0, -24'sd32700, 0);      // bottom wall
        send_particle(24'd100, 24'd0, -24'sd100, 24'd0, 1);            // crossing leftward
        drain();

        // thermal walls, zero energy included, partition with hole
        cfg_write(pvws_pkg::CFG_THERMO_EN, 24'd3);
        cfg_write(pvws_pkg::CFG_WALL_MODE, {22'd0, pvws_pkg::WALL_HOLE});
        cfg_write(pvws_pkg::CFG_TEMP_LEFT, 24'hFFFFFF);
        cfg_write(pvws_pkg::CFG_TEMP_RIGHT, 24'd0);
        send_particle(24'd65537, 24'd0, 24'd65537, 24'd0, 1);          // still, beyond wall
        send_particle(24'd65000, 24'd100, 24'd65500, 24'd100, 1);
        send_particle(-24'sd65000, 24'd100, -24'sd65500, 24'd300, 0);
        send_particle(-24'sd100, 24'd0, 24'd100, 24'd0, 0);            // through the hole
        send_particle(-24'sd100, 24'd5000, 24'd100, 24'd5000, 0);      // solid part
        send_particle(24'd100, 24'd0, -24'sd100, 24'd0, 1);
        drain();
        cfg_write(pvws_pkg::CFG_WALL_MODE, {22'd0, pvws_pkg::WALL_BLOCK_LR});
        send_particle(-24'sd100, 24'd0, 24'd100, 24'd0, 0);
        send_particle(24'd100, 24'd0, -24'sd100, 24'd0, 1);
        drain();
        cfg_write(pvws_pkg::CFG_WALL_MODE, {22'd0, pvws_pkg::WALL_BLOCK_RL});
        send_particle(-24'sd100, 24'd0, 24'd100, 24'd0, 0);
        send_particle(24'd100, 24'd0, -24'sd100, 24'd0, 1);
        drain();

        // random phases over several settings, extremes among them
        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(pvws_pkg::CFG_HALF_WIDTH, ph == 0 ? 24'd1 : ph == 1 ? 24'd32767
                                               : 24'($urandom_range(1, 400)));
            cfg_write(pvws_pkg::CFG_HALF_HEIGHT, ph == 0 ? 24'd32767 : ph == 1 ? 24'd1
                                                : 24'($urandom_range(1, 400)));
            cfg_write(pvws_pkg::CFG_HOLE_HALF, ph == 2 ? 24'd0 : ph == 3 ? 24'd32767
                                              : 24'($urandom_range(0, 100)));
            cfg_write(pvws_pkg::CFG_WALL_MODE, 24'(ph % 4));
            cfg_write(pvws_pkg::CFG_THERMO_EN, 24'($urandom_range(0, 3)));
            cfg_write(pvws_pkg::CFG_TEMP_LEFT, ph == 4 ? 24'd0
                      : 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 16)));
            cfg_write(pvws_pkg::CFG_TEMP_RIGHT, ph == 5 ? 24'hFFFFFF
                      : 24'($urandom_range(0, 4096)));
            repeat (100) random_particle();
            drain();
        end

        sink_busy = 0;
        if (motion_board.mismatches == 0 && motion_board.pending_q.size() == 0)
            $display("** particle_verlet_wall_step: PASSED **");
        else
            $display("** particle_verlet_wall_step: FAILED **");
        $finish;
    end
endmodule
